// ===== rtl/dhf_pkg.sv =====
package dhf_pkg;

    localparam int NUM_CELLS    = 16;
    localparam int CELL_IDX_W   = $clog2(NUM_CELLS);
    localparam int CNT_W        = $clog2(NUM_CELLS + 1);
    localparam int VAL_W        = 16;
    localparam int DIV_W        = 64;
    localparam int WEIGHT_SHIFT = 40;
    localparam int CHI_NUM      = 599;
    localparam int CHI_DEN      = 100;
    localparam int PIPE_LAT     = 5;

    typedef struct packed {
        logic [VAL_W-1:0] depth;
        logic [VAL_W-1:0] sigma;
    } hyp_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

    // Treat a zero sigma as one.
    function automatic logic [VAL_W-1:0] sigma_eff(input logic [VAL_W-1:0] s);
        sigma_eff = (s == '0) ? VAL_W'(1) : s;
    endfunction

endpackage

// ===== rtl/dhf_cell.sv =====
module dhf_cell import dhf_pkg::*; (
    input  logic aclk,
    input  logic shift_en,
    input  hyp_t d_in,
    output hyp_t q
);

    hyp_t hyp_reg;

    // Take the neighbor's hypothesis whenever the ring moves.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            hyp_reg <= d_in;
        end
    end

    assign q = hyp_reg;

endmodule

// ===== rtl/dhf_compat.sv =====
module dhf_compat import dhf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  hyp_t hyp_a,
    input  hyp_t hyp_b,
    output logic out_valid,
    output logic compatible
);

    logic [VAL_W-1:0] sa, sb, d;
    logic [15:0] d_1_reg;
    logic [31:0] sa2_1_reg, sb2_1_reg;
    logic [31:0] d2_2_reg;
    logic [32:0] ssum_2_reg;
    logic [63:0] prod_2_reg, prod_3_reg;
    logic [64:0] x_3_reg;
    logic [71:0] lhs_4_reg;
    logic [73:0] rhs_4_reg;
    logic        compat_5_reg;
    logic [PIPE_LAT-1:0] valid_reg;

    always_comb begin
        sa = sigma_eff(hyp_a.sigma);
        sb = sigma_eff(hyp_b.sigma);
        d  = (hyp_a.depth >= hyp_b.depth) ? hyp_a.depth - hyp_b.depth
                                          : hyp_b.depth - hyp_a.depth;
    end

    // 100*d^2*(sa^2+sb^2) < 599*sa^2*sb^2, multiplies spread over the pipeline stages
    always_ff @(posedge aclk) begin
        d_1_reg      <= d;
        sa2_1_reg    <= 32'(sa) * 32'(sa);
        sb2_1_reg    <= 32'(sb) * 32'(sb);
        d2_2_reg     <= 32'(d_1_reg) * 32'(d_1_reg);
        ssum_2_reg   <= {1'b0, sa2_1_reg} + {1'b0, sb2_1_reg};
        prod_2_reg   <= 64'(sa2_1_reg) * 64'(sb2_1_reg);
        x_3_reg      <= 65'(d2_2_reg) * 65'(ssum_2_reg);
        prod_3_reg   <= prod_2_reg;
        lhs_4_reg    <= 72'(x_3_reg) * 72'(CHI_DEN);
        rhs_4_reg    <= 74'(prod_3_reg) * 74'(CHI_NUM);
        compat_5_reg <= {2'b00, lhs_4_reg} < rhs_4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], in_valid};
        end
    end

    assign out_valid  = valid_reg[PIPE_LAT-1];
    assign compatible = compat_5_reg;

endmodule

// ===== rtl/dhf_div.sv =====
module dhf_div import dhf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_req_t         req,
    output logic             busy,
    output logic             done,
    output logic [DIV_W-1:0] quo
);

    localparam int STEP_W = $clog2(DIV_W);

    logic [DIV_W:0]    rem_reg, rem_sh, rem_step;
    logic [DIV_W-1:0]  quo_reg, den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg, ge;

    // Restoring division, one quotient bit a cycle.
    always_comb begin
        rem_sh   = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_step = ge ? rem_sh - {1'b0, den_reg} : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= '0;
                quo_reg  <= req.num;
                den_reg  <= req.den;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= rem_step;
                quo_reg  <= {quo_reg[DIV_W-2:0], ge};
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/dhf_isqrt.sv =====
module dhf_isqrt import dhf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_W-1:0]   x,
    output logic               done,
    output logic [DIV_W/2-1:0] root
);

    logic [DIV_W-1:0] x_reg, r_reg, bit_reg, sum;
    logic             busy_reg, done_reg;

    assign sum = r_reg + bit_reg;

    // Digit-by-digit square root, two radicand bits a cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x;
                r_reg    <= '0;
                bit_reg  <= DIV_W'(1) << (DIV_W - 2);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (x_reg >= sum) begin
                    x_reg <= x_reg - sum;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = r_reg[DIV_W/2-1:0];

endmodule

// ===== rtl/depth_hypothesis_fusion_top.sv =====
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid / s_tready       tdata {sigma, depth}, tlast = last of set
// m_        out  m_tvalid / m_tready       tdata {count, sigma, depth}, tuser {ovf, sup}
// cfg_      in   cfg_valid / cfg_ready     cfg_data = min_support
//
// Loading accepts one item per cycle while idle. After the item with tlast,
// the set of n hypotheses is scored: each hypothesis is picked out of the
// ring of 16 cells, swept past the shared compatibility pipeline, drained
// out of it and compared. Fusion then picks the chosen hypothesis, runs the
// serial divider for each compatible one, steps past every other stored one
// and each empty cell, then divides for depth and variance, takes the square
// root and hands out the result. Reset (aresetn low, synchronous) empties the
// set and sets min_support to 2. A result waiting on m_tready does not block
// loading of the next set; only its own finished result waits.
module depth_hypothesis_fusion_top import dhf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] inv_depth, [31:16] depth_sigma
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] fused_depth, [31:16] fused_sigma,
                                   // [35:32] support_count, [39:36] zero
    output logic [1:0]  m_tuser,   // [0] supported, [1] overflow
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // min_support
);

    typedef enum logic [3:0] {
        S_IDLE, S_PICK, S_SWEEP, S_DRAIN, S_NEXT, S_DECIDE, S_FSTEP, S_FWAIT,
        S_FDIVW, S_DIVD, S_DIVDW, S_DIVS, S_DIVSW, S_SQRTW, S_OUT
    } state_t;

    state_t state_reg;

    hyp_t cell_q [NUM_CELLS];
    hyp_t cell_d [NUM_CELLS];
    hyp_t in_hyp, tap, hyp_a_reg;
    logic shift_en, s_accept, store_ok;

    logic [CNT_W-1:0]      count_reg, n_reg, cnt_reg, best_cnt_reg;
    logic [CELL_IDX_W-1:0] t_reg, a_reg, best_reg, tap_idx, sel_idx;
    logic [CNT_W:0]        tap_sum;
    logic                  tap_valid, fuse_reg, drop_reg;
    logic [2:0]            dr_reg;
    logic [3:0]            min_support_reg, partners;

    logic pipe_in_v, pipe_out_v, pipe_compat;

    div_req_t         div_req;
    logic             div_busy, div_done;
    logic [DIV_W-1:0] div_q, num_reg, den_reg;
    logic [56:0]      wprod;
    logic             sq_done;
    logic [DIV_W/2-1:0] sq_root;
    logic [DIV_W/2:0]   sq_round;

    logic [VAL_W-1:0] depth_reg, sigma_reg;
    logic             m_valid_reg;
    logic [39:0]      m_data_reg;
    logic [1:0]       m_user_reg;

    assign in_hyp   = '{depth: s_tdata[15:0], sigma: s_tdata[31:16]};
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign store_ok = count_reg < CNT_W'(NUM_CELLS);
    assign tap      = cell_q[NUM_CELLS-1];

    // The ring turns the oldest stored entry to the tap first; an entry's index
    // follows from the step count and the fill level.
    assign tap_sum   = (CNT_W+1)'(t_reg) + (CNT_W+1)'(n_reg);
    assign tap_valid = tap_sum >= (CNT_W+1)'(NUM_CELLS);
    assign tap_idx   = tap_sum[CELL_IDX_W-1:0];
    assign sel_idx   = fuse_reg ? best_reg : a_reg;
    assign partners  = 4'(best_cnt_reg - CNT_W'(1));

    // Advance the ring on load, on every pick and sweep step, and once per
    // finished fusion step.
    always_comb begin
        shift_en = 1'b0;
        case (state_reg)
            S_IDLE:          shift_en = s_accept && store_ok;
            S_PICK, S_SWEEP: shift_en = 1'b1;
            S_FSTEP:         shift_en = !tap_valid;
            S_FWAIT:         shift_en = pipe_out_v && !pipe_compat;
            S_FDIVW:         shift_en = div_done;
            default:         shift_en = 1'b0;
        endcase
    end

    always_comb begin
        cell_d[0] = (state_reg == S_IDLE) ? in_hyp : cell_q[NUM_CELLS-1];
        for (int i = 1; i < NUM_CELLS; i++) begin
            cell_d[i] = cell_q[i-1];
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        dhf_cell u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .d_in     (cell_d[g]),
            .q        (cell_q[g])
        );
    end

    assign pipe_in_v = tap_valid && (state_reg == S_SWEEP || state_reg == S_FSTEP);

    dhf_compat u_compat (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (pipe_in_v),
        .hyp_a      (hyp_a_reg),
        .hyp_b      (tap),
        .out_valid  (pipe_out_v),
        .compatible (pipe_compat)
    );

    // Weight 2^40/s^2, then depth = (num + den/2)/den, then 2^42/den.
    always_comb begin
        div_req = '0;
        case (state_reg)
            S_FWAIT: begin
                div_req.start = pipe_out_v && pipe_compat;
                div_req.num   = DIV_W'(1) << WEIGHT_SHIFT;
                div_req.den   = DIV_W'(32'(sigma_eff(tap.sigma)) *
                                       32'(sigma_eff(tap.sigma)));
            end
            S_DIVD: begin
                div_req.start = 1'b1;
                div_req.num   = num_reg + (den_reg >> 1);
                div_req.den   = den_reg;
            end
            S_DIVS: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_W'(1) << (WEIGHT_SHIFT + 2);
                div_req.den   = den_reg;
            end
            default: div_req = '0;
        endcase
    end

    dhf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_q)
    );

    dhf_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   ((state_reg == S_DIVSW) && div_done),
        .x       (div_q),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign wprod    = 57'(tap.depth) * 57'(div_q[WEIGHT_SHIFT:0]);
    assign sq_round = ((DIV_W/2+1)'(sq_root) + (DIV_W/2+1)'(1)) >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            drop_reg        <= 1'b0;
            n_reg           <= '0;
            t_reg           <= '0;
            a_reg           <= '0;
            best_reg        <= '0;
            cnt_reg         <= '0;
            best_cnt_reg    <= '0;
            fuse_reg        <= 1'b0;
            dr_reg          <= '0;
            m_valid_reg     <= 1'b0;
            min_support_reg <= 4'd2;
        end else begin
            if (cfg_valid) begin
                min_support_reg <= cfg_data;
            end
            // Drop the handed-out result unless a new one takes its place.
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            // Count compatible partners as the sweep results drain out.
            if ((state_reg == S_SWEEP || state_reg == S_DRAIN) &&
                pipe_out_v && pipe_compat) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (store_ok) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end else begin
                            drop_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            n_reg        <= store_ok ? count_reg + CNT_W'(1) : count_reg;
                            a_reg        <= '0;
                            best_reg     <= '0;
                            best_cnt_reg <= '0;
                            cnt_reg      <= '0;
                            fuse_reg     <= 1'b0;
                            t_reg        <= '0;
                            state_reg    <= S_PICK;
                        end
                    end
                end
                S_PICK: begin
                    if (tap_valid && tap_idx == sel_idx) begin
                        hyp_a_reg <= tap;
                    end
                    t_reg <= t_reg + CELL_IDX_W'(1);
                    if (t_reg == CELL_IDX_W'(NUM_CELLS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= fuse_reg ? S_FSTEP : S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    t_reg <= t_reg + CELL_IDX_W'(1);
                    if (t_reg == CELL_IDX_W'(NUM_CELLS - 1)) begin
                        dr_reg    <= '0;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    dr_reg <= dr_reg + 3'd1;
                    if (dr_reg == 3'(PIPE_LAT - 1)) begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    // Strict compare keeps the earliest hypothesis on a tie.
                    if (cnt_reg > best_cnt_reg) begin
                        best_cnt_reg <= cnt_reg;
                        best_reg     <= a_reg;
                    end
                    if (CNT_W'(a_reg) == n_reg - CNT_W'(1)) begin
                        state_reg <= S_DECIDE;
                    end else begin
                        a_reg     <= a_reg + CELL_IDX_W'(1);
                        state_reg <= S_PICK;
                    end
                end
                S_DECIDE: begin
                    if (n_reg != '0 && partners >= min_support_reg) begin
                        num_reg   <= '0;
                        den_reg   <= '0;
                        fuse_reg  <= 1'b1;
                        t_reg     <= '0;
                        state_reg <= S_PICK;
                    end else begin
                        depth_reg <= '0;
                        sigma_reg <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_FSTEP: begin
                    if (tap_valid) begin
                        state_reg <= S_FWAIT;
                    end else begin
                        t_reg     <= t_reg + CELL_IDX_W'(1);
                        state_reg <= (t_reg == CELL_IDX_W'(NUM_CELLS - 1)) ? S_DIVD : S_FSTEP;
                    end
                end
                S_FWAIT: begin
                    if (pipe_out_v) begin
                        if (pipe_compat) begin
                            state_reg <= S_FDIVW;
                        end else begin
                            t_reg     <= t_reg + CELL_IDX_W'(1);
                            state_reg <= (t_reg == CELL_IDX_W'(NUM_CELLS - 1)) ?
                                         S_DIVD : S_FSTEP;
                        end
                    end
                end
                S_FDIVW: begin
                    // Accumulate depth*w and w for this compatible hypothesis.
                    if (div_done) begin
                        num_reg   <= num_reg + DIV_W'(wprod);
                        den_reg   <= den_reg + div_q;
                        t_reg     <= t_reg + CELL_IDX_W'(1);
                        state_reg <= (t_reg == CELL_IDX_W'(NUM_CELLS - 1)) ? S_DIVD : S_FSTEP;
                    end
                end
                S_DIVD: begin
                    state_reg <= S_DIVDW;
                end
                S_DIVDW: begin
                    if (div_done) begin
                        depth_reg <= (|div_q[DIV_W-1:VAL_W]) ? '1 : div_q[VAL_W-1:0];
                        state_reg <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    state_reg <= S_DIVSW;
                end
                S_DIVSW: begin
                    if (div_done) begin
                        state_reg <= S_SQRTW;
                    end
                end
                S_SQRTW: begin
                    if (sq_done) begin
                        sigma_reg <= (|sq_round[DIV_W/2:VAL_W]) ? '1 : sq_round[VAL_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hold the result until the output register is free.
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'b0000, partners, sigma_reg, depth_reg};
                        m_user_reg  <= {drop_reg, fuse_reg};
                        count_reg   <= '0;
                        drop_reg    <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign m_tlast   = 1'b1;
    assign cfg_ready = 1'b1;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(NUM_CELLS))
        else $error("store fill level beyond capacity");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");

    a_set_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!m_valid_reg || m_tready)) |=>
            (count_reg == '0 && !drop_reg && state_reg == S_IDLE))
        else $error("set not cleared after result");

endmodule

// ===== tb/sv/tb_depth_hypothesis_fusion_top.sv =====
`timescale 1ns / 1ps

module tb_depth_hypothesis_fusion_top;
    import dhf_pkg::*;

    localparam int STORE_DEPTH = 16;
    localparam int STALL_LIMIT = 40000;   // cycles without any handshake
    localparam int DRAIN_WAIT  = 400;

    typedef struct {
        logic [15:0] depth;
        logic [15:0] sigma;
        logic        sup;
        logic [3:0]  count;
        logic        ovf;
    } fusion_t;

    // Tracks the hypothesis set and predicts the fused result of each closed set.
    class fusion_scoreboard;
        logic [15:0] depths [STORE_DEPTH];
        logic [15:0] sigmas [STORE_DEPTH];
        int          loaded;
        bit          dropped;
        logic [3:0]  min_support;
        fusion_t     pending[$];
        int          errors;
        int          results;
        int          supported_seen;
        int          overflow_seen;

        function new();
            loaded = 0;
            dropped = 0;
            min_support = 4'd2;
            errors = 0;
            results = 0;
            supported_seen = 0;
            overflow_seen = 0;
        endfunction

        function logic [127:0] eff_sigma(logic [15:0] s);
            return (s == 16'd0) ? 128'd1 : 128'(s);
        endfunction

        // chi-square gate in exact integers: 100*d^2*(sa^2+sb^2) < 599*sa^2*sb^2
        function bit agrees(int a, int b);
            logic [127:0] d, sa2, sb2;
            d = (depths[a] > depths[b]) ? 128'(depths[a] - depths[b])
                                        : 128'(depths[b] - depths[a]);
            sa2 = eff_sigma(sigmas[a]) * eff_sigma(sigmas[a]);
            sb2 = eff_sigma(sigmas[b]) * eff_sigma(sigmas[b]);
            return (128'(CHI_DEN) * d * d * (sa2 + sb2)) < (128'(CHI_NUM) * sa2 * sb2);
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] r, pw;
            r = 0;
            pw = 64'd1 << 62;
            while (pw > x) pw >>= 2;
            while (pw != 0) begin
                if (x >= r + pw) begin
                    x -= r + pw;
                    r = (r >> 1) + pw;
                end else begin
                    r >>= 1;
                end
                pw >>= 2;
            end
            return r;
        endfunction

        function void note_item(logic [15:0] d, logic [15:0] s, logic last);
            fusion_t     res;
            int          best, best_cnt, cnt, partners;
            logic [63:0] num, den, w, sd, q, dep, sig;
            if (loaded < STORE_DEPTH) begin
                depths[loaded] = d;
                sigmas[loaded] = s;
                loaded++;
            end else begin
                dropped = 1;
            end
            if (!last) return;

            best = 0;
            best_cnt = 0;
            for (int a = 0; a < loaded; a++) begin
                cnt = 0;
                for (int b = 0; b < loaded; b++)
                    if (agrees(a, b)) cnt++;
                if (cnt > best_cnt) begin
                    best_cnt = cnt;
                    best = a;
                end
            end
            partners = (best_cnt > 0) ? best_cnt - 1 : 0;

            res = '{depth: 16'd0, sigma: 16'd0, sup: 1'b0, count: 4'd0, ovf: dropped};
            res.count = (partners > 15) ? 4'd15 : 4'(partners);
            if (loaded > 0 && partners >= min_support) begin
                num = 0;
                den = 0;
                for (int b = 0; b < loaded; b++) begin
                    if (agrees(best, b)) begin
                        sd = 64'(eff_sigma(sigmas[b]));
                        w = (64'd1 << WEIGHT_SHIFT) / (sd * sd);
                        num += 64'(depths[b]) * w;
                        den += w;
                    end
                end
                dep = (num + den / 2) / den;
                q = int_sqrt((64'd1 << (WEIGHT_SHIFT + 2)) / den);
                sig = (q + 1) >> 1;
                res.depth = (dep > 64'hFFFF) ? 16'hFFFF : dep[15:0];
                res.sigma = (sig > 64'hFFFF) ? 16'hFFFF : sig[15:0];
                res.sup = 1'b1;
            end
            pending.insert(pending.size(), res);
            loaded = 0;
            dropped = 0;
        endfunction

        function void check_result(logic [39:0] data, logic [1:0] user);
            fusion_t exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result: tdata=%h tuser=%b", data, user);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            results++;
            if (user[0]) supported_seen++;
            if (user[1]) overflow_seen++;
            if (data[15:0] !== exp_r.depth) begin
                $error("fused_depth: expected %0d, got %0d", exp_r.depth, data[15:0]);
                errors++;
            end
            if (data[31:16] !== exp_r.sigma) begin
                $error("fused_sigma: expected %0d, got %0d", exp_r.sigma, data[31:16]);
                errors++;
            end
            if (data[35:32] !== exp_r.count) begin
                $error("support_count: expected %0d, got %0d", exp_r.count, data[35:32]);
                errors++;
            end
            if (user[0] !== exp_r.sup) begin
                $error("supported: expected %0d, got %0d", exp_r.sup, user[0]);
                errors++;
            end
            if (user[1] !== exp_r.ovf) begin
                $error("overflow: expected %0d, got %0d", exp_r.ovf, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    fusion_scoreboard sb = new();
    int idle_pct  = 0;    // sender gap chance, percent
    int stall_pct = 0;    // receiver stall chance, percent
    int quiet_cycles = 0;
    int items_sent = 0;

    always #5 aclk = ~aclk;

    depth_hypothesis_fusion_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Monitor every handshake at the edge, then redraw the receiver's ready.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_item(s_tdata[15:0], s_tdata[31:16], s_tlast);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
            if (cfg_valid && cfg_ready) begin
                sb.min_support = cfg_data;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("FAIL depth_hypothesis_fusion_top");
            $finish;
        end
    end

    // Offer one hypothesis, with random gaps ahead of it; hold valid until taken.
    task automatic send_hyp(logic [15:0] d, logic [15:0] s, logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s, d};
        s_tlast  <= last;
        items_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_min_support(logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One set: mostly a cluster around a center scaled to its sigma, some noise.
    task automatic send_random_set();
        int          n, c, sg, dv;
        logic [15:0] s;
        bit          noisy;
        n = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 7);
        c = $urandom_range(65535);
        sg = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1, 2048);
        for (int i = 0; i < n; i++) begin
            noisy = ($urandom_range(4) == 0);
            if (noisy) begin
                dv = $urandom_range(65535);
                s = 16'($urandom_range(65535));
            end else begin
                s = 16'($urandom_range(sg / 2, sg));
                dv = c + $signed($urandom_range(0, 2 * sg)) - sg;
                if (dv < 0) dv = 0;
                if (dv > 65535) dv = 65535;
            end
            send_hyp(16'(dv), s, i == n - 1);
        end
    endtask

    initial begin
        int phase_support [4];
        int phase_idle [4];
        int phase_stall [4];
        phase_support = '{0, 15, 1, 0};
        phase_support[3] = $urandom_range(3, 14);
        phase_idle  = '{0, 81, 0, 35};
        phase_stall = '{0, 0, 81, 35};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, zero sigma, a single item, reset min_support.
        send_hyp(16'h0000, 16'h0000, 1'b0);
        send_hyp(16'hFFFF, 16'hFFFF, 1'b0);
        send_hyp(16'hFFFF, 16'h0001, 1'b0);
        send_hyp(16'h0000, 16'hFFFF, 1'b0);
        send_hyp(16'h1F40, 16'h0000, 1'b1);
        send_hyp(16'h8000, 16'h0100, 1'b1);
        drain();

        // Directed: overfull set of near-equal hypotheses at the top support setting.
        write_min_support(4'd15);
        for (int i = 0; i < 18; i++)
            send_hyp(16'h4000 + 16'(i), 16'h0400, i == 17);
        drain();

        // Random phases, each with its own support setting and handshake pressure.
        for (int p = 0; p < 4; p++) begin
            write_min_support(4'(phase_support[p]));
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            while (items_sent < 24 + 100 * (p + 1)) send_random_set();
            drain();
        end

        $display("sent %0d hypotheses, checked %0d fused results", items_sent, sb.results);
        $display("%0d results supported, %0d flagged overflow",
                 sb.supported_seen, sb.overflow_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS depth_hypothesis_fusion_top");
        end else begin
            $display("FAIL depth_hypothesis_fusion_top");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dhf_pkg.sv
rtl/dhf_cell.sv
rtl/dhf_compat.sv
rtl/dhf_div.sv
rtl/dhf_isqrt.sv
rtl/depth_hypothesis_fusion_top.sv
tb/sv/tb_depth_hypothesis_fusion_top.sv
